@@ sv/ulrb_pkg.sv @@
package ulrb_pkg;

    localparam int RX_DEPTH    = 256;
    localparam int PTR_W       = $clog2(RX_DEPTH);
    localparam int AT_BUF_SIZE = 64;
    localparam int FILL_W      = $clog2(AT_BUF_SIZE);
    localparam int LINE_MAX    = 64;
    localparam int LEN_W       = 6;
    localparam int IDLE_W      = 17;
    localparam int TIMEOUT_W   = 16;

    localparam logic [IDLE_W-1:0]    IDLE_MAX      = {IDLE_W{1'b1}};
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5000;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_O  = 8'h4F;
    localparam logic [7:0] CH_K  = 8'h4B;
    localparam logic [7:0] CH_E  = 8'h45;
    localparam logic [7:0] CH_R  = 8'h52;

    typedef enum logic [1:0] {
        FUNC_BYTE = 2'd0,
        FUNC_READ = 2'd1,
        FUNC_TICK = 2'd2,
        FUNC_NOP  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        AT_NONE = 2'd0,
        AT_OK   = 2'd1,
        AT_ERR  = 2'd2,
        AT_NL   = 2'd3
    } at_end_t;

    typedef struct packed {
        logic       go;
        func_t      func;
        logic [7:0] rx_byte;
    } link_ev_t;

    typedef struct packed {
        logic    done;
        at_end_t endc;
        logic    connected;
    } link_stat_t;

    typedef struct packed {
        logic             wr;
        logic [7:0]       wdata;
        logic             start;
        logic [LEN_W-1:0] limit;
        logic             take;
    } line_cmd_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [7:0]       data;
        logic             found;
        logic [LEN_W-1:0] length;
    } line_res_t;

endpackage

@@ sv/ulrb_link.sv @@
module ulrb_link
    import ulrb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  link_ev_t             ev,
    input  logic                 cfg_we,
    input  logic [TIMEOUT_W-1:0] cfg_data,
    output link_stat_t           stat
);

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [IDLE_W-1:0]    idle_reg, idle_next;
    logic                 link_reg, link_next, link_base;
    logic [FILL_W-1:0]    fill_reg, fill_next, fill_inc;
    logic [15:0]          recent_reg, recent_next;
    logic                 done_reg, done_next;
    at_end_t              endc_reg, endc_next;

    always_comb
    begin
        idle_next   = idle_reg;
        fill_next   = fill_reg;
        recent_next = recent_reg;
        done_next   = done_reg;
        endc_next   = endc_reg;
        link_base   = link_reg;
        link_next   = link_reg;
        fill_inc    = fill_reg + 1'b1;
        if (ev.go)
        begin
            done_next = 1'b0;
            endc_next = AT_NONE;
            case (ev.func)
                FUNC_BYTE:
                begin
                    idle_next = '0;
                    link_base = 1'b1;
                    if (fill_reg < FILL_W'(AT_BUF_SIZE - 1))
                    begin
                        fill_next = fill_inc;
                        if (fill_inc >= FILL_W'(2) && recent_reg[7:0] == CH_O && ev.rx_byte == CH_K)
                            endc_next = AT_OK;
                        else if (fill_inc >= FILL_W'(3) && recent_reg[15:8] == CH_E
                                 && recent_reg[7:0] == CH_R && ev.rx_byte == CH_R)
                            endc_next = AT_ERR;
                        else if (ev.rx_byte == CH_LF)
                            endc_next = AT_NL;
                        if (endc_next != AT_NONE)
                        begin
                            fill_next = '0;
                            done_next = 1'b1;
                        end
                        recent_next = {recent_reg[7:0], ev.rx_byte};
                    end
                    else
                        fill_next = '0;
                end
                FUNC_TICK:
                begin
                    if (idle_reg < IDLE_MAX)
                        idle_next = idle_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
            link_next = (idle_next > IDLE_W'(timeout_reg)) ? 1'b0 : link_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            idle_reg    <= '0;
            link_reg    <= 1'b0;
            fill_reg    <= '0;
            recent_reg  <= '0;
            done_reg    <= 1'b0;
            endc_reg    <= AT_NONE;
        end
        else
        begin
            if (cfg_we)
                timeout_reg <= cfg_data;
            idle_reg   <= idle_next;
            link_reg   <= link_next;
            fill_reg   <= fill_next;
            recent_reg <= recent_next;
            done_reg   <= done_next;
            endc_reg   <= endc_next;
        end
    end

    assign stat.done      = done_reg;
    assign stat.endc      = endc_reg;
    assign stat.connected = link_reg;

endmodule

@@ sv/ulrb_line.sv @@
module ulrb_line
    import ulrb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  line_cmd_t  cmd,
    output line_res_t  res,
    output logic [7:0] bytes_avail
);

    typedef enum logic [3:0] {
        L_IDLE  = 4'b0001,
        L_SCAN  = 4'b0010,
        L_EMIT  = 4'b0100,
        L_FINAL = 4'b1000
    } lstate_t;

    lstate_t          state_reg, state_next;
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [PTR_W-1:0] base_reg, base_next;
    logic [PTR_W-1:0] addr_reg, addr_next;
    logic [PTR_W-1:0] left_reg, left_next;
    logic             qv_reg, qv_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] emit_reg, emit_next;
    logic [LEN_W-1:0] limit_reg, limit_next;
    logic             found_reg, found_next;

    logic [7:0]       mem [RX_DEPTH];
    logic [7:0]       mem_q;
    logic             rd_en;
    logic [PTR_W-1:0] held;
    logic [12:0]      held_wide;
    logic             is_nl, chr_ok, consume;

    assign held      = wptr_reg - rptr_reg;
    assign held_wide = 13'(held);
    assign is_nl     = qv_reg && mem_q == CH_LF;
    assign chr_ok    = qv_reg && mem_q != CH_CR;
    assign consume   = qv_reg && (mem_q == CH_CR || cmd.take);

    always_comb
    begin
        state_next = state_reg;
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        base_next  = base_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        qv_next    = qv_reg;
        cnt_next   = cnt_reg;
        emit_next  = emit_reg;
        limit_next = limit_reg;
        found_next = found_reg;
        rd_en      = 1'b0;
        if (cmd.wr)
            wptr_next = wptr_reg + 1'b1;
        unique case (state_reg)
            L_IDLE:
            begin
                if (cmd.start)
                begin
                    base_next  = rptr_reg;
                    addr_next  = rptr_reg;
                    left_next  = held;
                    qv_next    = 1'b0;
                    cnt_next   = '0;
                    emit_next  = '0;
                    limit_next = cmd.limit;
                    found_next = 1'b0;
                    state_next = L_SCAN;
                end
            end
            L_SCAN:
            begin
                if (is_nl)
                begin
                    // first newline sits at addr_reg - 1; the line always ends past it
                    found_next = 1'b1;
                    rptr_next  = addr_reg;
                    addr_next  = base_reg;
                    qv_next    = 1'b0;
                    state_next = (cnt_reg == '0) ? L_FINAL : L_EMIT;
                end
                else
                begin
                    if (chr_ok && cnt_reg < limit_reg)
                        cnt_next = cnt_reg + 1'b1;
                    if (left_reg != '0)
                    begin
                        rd_en     = 1'b1;
                        addr_next = addr_reg + 1'b1;
                        left_next = left_reg - 1'b1;
                        qv_next   = 1'b1;
                    end
                    else
                    begin
                        qv_next = 1'b0;
                        if (!qv_reg)
                        begin
                            cnt_next   = '0;
                            state_next = L_FINAL;
                        end
                    end
                end
            end
            L_EMIT:
            begin
                if (chr_ok && cmd.take)
                begin
                    emit_next = emit_reg + 1'b1;
                    if (emit_next == cnt_reg)
                        state_next = L_FINAL;
                end
                if (!qv_reg || consume)
                begin
                    rd_en     = 1'b1;
                    addr_next = addr_reg + 1'b1;
                    qv_next   = 1'b1;
                end
            end
            L_FINAL:
            begin
                if (cmd.take)
                    state_next = L_IDLE;
            end
            default:
                state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
            mem[wptr_reg] <= cmd.wdata;
        if (rd_en)
            mem_q <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            qv_reg    <= 1'b0;
            cnt_reg   <= '0;
            emit_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            qv_reg    <= qv_next;
            cnt_reg   <= cnt_next;
            emit_reg  <= emit_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        addr_reg  <= addr_next;
        left_reg  <= left_next;
        limit_reg <= limit_next;
    end

    assign res.valid  = (state_reg == L_EMIT && chr_ok) || state_reg == L_FINAL;
    assign res.last   = (state_reg == L_FINAL);
    assign res.data   = (state_reg == L_EMIT) ? mem_q : 8'h00;
    assign res.found  = found_reg;
    assign res.length = cnt_reg;

    assign bytes_avail = (held_wide > 13'd255) ? 8'hFF : held_wide[7:0];

endmodule

@@ sv/uart_line_receive_buffer_top.sv @@
// UART receive buffer with line reader, AT-response detector and link monitor.
// Input channel (in_valid / in_stall): func selects byte received, line read
// or millisecond tick; rx_byte and max_len ride along. Output channel
// (out_valid / out_stall) carries one result per transfer; last marks the
// final result of an item. Config channel (cfg_valid / cfg_ready, always
// ready) writes idle_timeout_ms; write it only while the block is idle.
// Byte, tick and no-op items: accepted in T_IDLE, then one result is loaded in
// T_RESP once the output is free; no new item is accepted before that.
// Line read: the ring store (256 x 8, one read port, registered read) is
// scanned one byte per cycle for a newline; then the line is read out again
// at one byte per cycle while out_stall is low, one result per character
// with CR bytes skipped, then the closing result.
// Reset clears pointers, AT detector, idle time and link state and sets the
// timeout to 5000 ms; the store contents are not cleared.
// out_stall holds the current result and the block stops producing; in_stall
// is high whenever an item is still in progress.
module uart_line_receive_buffer_top
    import ulrb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           func,
    input  logic [7:0]           rx_byte,
    input  logic [6:0]           max_len,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 char_valid,
    output logic [7:0]           line_char,
    output logic                 line_found,
    output logic [LEN_W-1:0]     line_length,
    output logic                 last,
    output logic                 at_response_done,
    output logic [1:0]           at_response_end,
    output logic                 connected,
    output logic [7:0]           bytes_available,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TIMEOUT_W-1:0] idle_timeout_ms
);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_RESP = 3'b010,
        T_READ = 3'b100
    } tstate_t;

    tstate_t          state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             char_valid_reg;
    logic [7:0]       line_char_reg;
    logic             line_found_reg;
    logic [LEN_W-1:0] line_length_reg;
    logic             last_reg;
    logic             done_reg;
    logic [1:0]       endc_reg;
    logic             connected_reg;
    logic [7:0]       avail_reg;

    logic             accept;
    logic             out_free;
    logic             load_resp, load_line;
    logic [LEN_W-1:0] limit;
    link_ev_t         ev;
    link_stat_t       stat;
    line_cmd_t        cmd;
    line_res_t        res;
    logic [7:0]       avail;

    assign in_stall  = (state_reg != T_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (max_len == 7'd0)
            limit = '0;
        else if (max_len > 7'(LINE_MAX))
            limit = LEN_W'(LINE_MAX - 1);
        else
            limit = LEN_W'(max_len - 7'd1);
    end

    assign ev.go      = accept;
    assign ev.func    = func_t'(func);
    assign ev.rx_byte = rx_byte;

    assign cmd.wr    = accept && func_t'(func) == FUNC_BYTE;
    assign cmd.wdata = rx_byte;
    assign cmd.start = accept && func_t'(func) == FUNC_READ;
    assign cmd.limit = limit;
    assign cmd.take  = out_free && state_reg == T_READ;

    ulrb_link u_link (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev       (ev),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (idle_timeout_ms),
        .stat     (stat)
    );

    ulrb_line u_line (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .res         (res),
        .bytes_avail (avail)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        load_resp      = 1'b0;
        load_line      = 1'b0;
        if (out_free)
            out_valid_next = 1'b0;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                    state_next = (func_t'(func) == FUNC_READ) ? T_READ : T_RESP;
            end
            T_RESP:
            begin
                if (out_free)
                begin
                    load_resp      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = T_IDLE;
                end
            end
            T_READ:
            begin
                if (out_free && res.valid)
                begin
                    load_line      = 1'b1;
                    out_valid_next = 1'b1;
                    if (res.last)
                        state_next = T_IDLE;
                end
            end
            default:
                state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_resp)
        begin
            char_valid_reg  <= 1'b0;
            line_char_reg   <= 8'h00;
            line_found_reg  <= 1'b0;
            line_length_reg <= '0;
            last_reg        <= 1'b1;
            done_reg        <= stat.done;
            endc_reg        <= stat.endc;
            connected_reg   <= stat.connected;
            avail_reg       <= avail;
        end
        else if (load_line)
        begin
            char_valid_reg  <= !res.last;
            line_char_reg   <= res.data;
            line_found_reg  <= res.found;
            line_length_reg <= res.length;
            last_reg        <= res.last;
            done_reg        <= 1'b0;
            endc_reg        <= AT_NONE;
            connected_reg   <= stat.connected;
            avail_reg       <= avail;
        end
    end

    assign out_valid        = out_valid_reg;
    assign char_valid       = char_valid_reg;
    assign line_char        = line_char_reg;
    assign line_found       = line_found_reg;
    assign line_length      = line_length_reg;
    assign last             = last_reg;
    assign at_response_done = done_reg;
    assign at_response_end  = endc_reg;
    assign connected        = connected_reg;
    assign bytes_available  = avail_reg;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import ulrb_pkg::*;

    typedef struct packed {
        logic             char_valid;
        logic [7:0]       line_char;
        logic             line_found;
        logic [LEN_W-1:0] line_length;
        logic             last;
        logic             at_done;
        at_end_t          at_end;
        logic             connected;
        logic [7:0]       avail;
    } buf_status_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           func = 2'd0;
    logic [7:0]           rx_byte = 8'd0;
    logic [6:0]           max_len = 7'd0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 char_valid;
    logic [7:0]           line_char;
    logic                 line_found;
    logic [LEN_W-1:0]     line_length;
    logic                 last;
    logic                 at_response_done;
    logic [1:0]           at_response_end;
    logic                 connected;
    logic [7:0]           bytes_available;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [TIMEOUT_W-1:0] idle_timeout_ms = '0;

    uart_line_receive_buffer_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .rx_byte          (rx_byte),
        .max_len          (max_len),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .char_valid       (char_valid),
        .line_char        (line_char),
        .line_found       (line_found),
        .line_length      (line_length),
        .last             (last),
        .at_response_done (at_response_done),
        .at_response_end  (at_response_end),
        .connected        (connected),
        .bytes_available  (bytes_available),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .idle_timeout_ms  (idle_timeout_ms)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mirror of the block state
    logic [7:0]           rx_mirror [RX_DEPTH];
    logic [PTR_W-1:0]     wr_ptr = '0;
    logic [PTR_W-1:0]     rd_ptr = '0;
    logic [FILL_W-1:0]    at_fill = '0;
    logic [15:0]          at_recent = '0;
    logic [IDLE_W-1:0]    idle_cnt = '0;
    logic                 link_up = 1'b0;
    logic [TIMEOUT_W-1:0] timeout_mirror = TIMEOUT_RESET;

    buf_status_t due_status[$];

    bit no_gaps = 1'b0;
    int stall_left = 0;
    int error_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int reads_sent = 0;
    int chars_read = 0;
    int timeout_writes = 0;

    function automatic int draw_wait();
        return no_gaps ? 0 : int'($urandom_range(0, 7));
    endfunction

    function automatic logic [7:0] held_bytes();
        return wr_ptr - rd_ptr;
    endfunction

    function automatic logic [7:0] pick_plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_LF || b == CH_CR || b == CH_K || b == CH_R);
        return b;
    endfunction

    function automatic logic [7:0] pick_non_lf();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_LF);
        return b;
    endfunction

    task automatic predict_buffer_item(input func_t f, input logic [7:0] b,
                                       input logic [6:0] ml);
        buf_status_t r;
        logic [7:0]  line_q[$];
        logic [7:0]  p1, p2, c;
        logic [7:0]  scan;
        int          limit, i, n;
        bit          found, got_nl;
        at_end_t     endc;
        bit          done;
        endc = AT_NONE;
        done = 1'b0;
        found = 1'b0;
        got_nl = 1'b0;
        case (f)
            FUNC_BYTE:
            begin
                rx_mirror[wr_ptr] = b;
                wr_ptr = wr_ptr + 1'b1;
                idle_cnt = '0;
                link_up = 1'b1;
                if (int'(at_fill) < AT_BUF_SIZE - 1)
                begin
                    p1 = at_recent[7:0];
                    p2 = at_recent[15:8];
                    at_fill = at_fill + 1'b1;
                    if (at_fill >= 2 && p1 == CH_O && b == CH_K)
                        endc = AT_OK;
                    else if (at_fill >= 3 && p2 == CH_E && p1 == CH_R && b == CH_R)
                        endc = AT_ERR;
                    else if (b == CH_LF)
                        endc = AT_NL;
                    if (endc != AT_NONE)
                    begin
                        at_fill = '0;
                        done = 1'b1;
                    end
                    at_recent = {at_recent[7:0], b};
                end
                else
                begin
                    at_fill = '0;
                end
            end
            FUNC_TICK:
            begin
                if (idle_cnt != IDLE_MAX)
                    idle_cnt = idle_cnt + 1'b1;
            end
            FUNC_READ:
            begin
                reads_sent++;
                if (ml == 0)
                    limit = 0;
                else if (ml > LINE_MAX)
                    limit = LINE_MAX - 1;
                else
                    limit = int'(ml) - 1;
                scan = rd_ptr;
                n = int'(held_bytes());
                i = 0;
                while (!found && i < n)
                begin
                    if (rx_mirror[scan] == CH_LF)
                        found = 1'b1;
                    else
                    begin
                        scan = scan + 1'b1;
                        i++;
                    end
                end
                if (found)
                begin
                    while (line_q.size() < limit && held_bytes() != 0 && !got_nl)
                    begin
                        c = rx_mirror[rd_ptr];
                        rd_ptr = rd_ptr + 1'b1;
                        if (c == CH_LF)
                            got_nl = 1'b1;
                        else if (c != CH_CR)
                            line_q.push_back(c);
                    end
                    // rest of the line dropped only on truncation
                    while (!got_nl && held_bytes() != 0)
                    begin
                        c = rx_mirror[rd_ptr];
                        rd_ptr = rd_ptr + 1'b1;
                        if (c == CH_LF)
                            got_nl = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (idle_cnt > timeout_mirror)
            link_up = 1'b0;

        r = '0;
        r.connected = link_up;
        r.avail = held_bytes();
        if (f == FUNC_READ)
        begin
            r.line_found = found;
            r.line_length = LEN_W'(line_q.size());
            foreach (line_q[k])
            begin
                r.char_valid = 1'b1;
                r.line_char = line_q[k];
                due_status.push_back(r);
            end
            chars_read += line_q.size();
            r.char_valid = 1'b0;
            r.line_char = '0;
        end
        else
        begin
            r.at_done = done;
            r.at_end = endc;
        end
        r.last = 1'b1;
        due_status.push_back(r);
    endtask

    // called at a rising edge; returns at the edge of the transfer
    task automatic send_item(input func_t f, input logic [7:0] b, input logic [6:0] ml);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        rx_byte <= b;
        max_len <= ml;
        predict_buffer_item(f, b, ml);
        items_sent++;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(FUNC_BYTE, b, 7'($urandom_range(0, 127)));
    endtask

    task automatic send_read(input logic [6:0] ml);
        send_item(FUNC_READ, 8'($urandom_range(0, 255)), ml);
    endtask

    task automatic send_tick();
        send_item(FUNC_TICK, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    endtask

    task automatic send_nop();
        send_item(FUNC_NOP, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic flush_lines();
        if (held_bytes() != 0 && rx_mirror[wr_ptr - 1'b1] != CH_LF)
            send_byte(CH_LF);
        while (held_bytes() != 0)
            send_read(7'd64);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (due_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_idle_timeout(input logic [TIMEOUT_W-1:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        idle_timeout_ms <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        timeout_mirror = v;
        timeout_writes++;
    endtask

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 100)
            $display("ERROR: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("result %0d: %s is 0x%0h, want 0x%0h",
                                   results_seen, name, got, want));
    endtask

    always @(posedge clk)
    begin
        buf_status_t want;
        if (out_valid && !out_stall)
        begin
            if (due_status.size() == 0)
                report_error($sformatf("result %0d arrived with nothing pending",
                                       results_seen));
            else
            begin
                want = due_status.pop_front();
                check_field("char_valid", char_valid, want.char_valid);
                check_field("line_char", line_char, want.line_char);
                check_field("line_found", line_found, want.line_found);
                check_field("line_length", line_length, want.line_length);
                check_field("last", last, want.last);
                check_field("at_response_done", at_response_done, want.at_done);
                check_field("at_response_end", at_response_end, want.at_end);
                check_field("connected", connected, want.connected);
                check_field("bytes_available", bytes_available, want.avail);
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            stall_left = draw_wait();
        else if (stall_left > 0)
            stall_left = stall_left - 1;
        out_stall <= (stall_left > 0);
    end

    task automatic test_directed();
        send_nop();
        send_read(7'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("OK");
        send_text("ERR");
        send_byte("A");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_read(7'd64);
        send_text("abcd");
        send_byte(CH_LF);
        send_read(7'd3);
        send_text("x\ny\n");
        send_read(7'd127);
        send_read(7'd2);
        send_byte("q");
        send_read(7'd1);
        send_byte(CH_LF);
        send_read(7'd1);
        send_tick();
        send_nop();
    endtask

    task automatic test_idle_timeout();
        no_gaps = 1'b1;
        send_byte(pick_plain_byte());
        repeat (3) send_tick();
        send_nop();
        no_gaps = 1'b0;
        set_idle_timeout(16'd0);
        send_byte(pick_plain_byte());
        send_nop();
        send_tick();
        send_byte(pick_plain_byte());
        set_idle_timeout(16'hFFFF);
        repeat (10) send_tick();
        send_read(7'd5);
        set_idle_timeout(16'd4);
        send_nop();
        send_byte(pick_plain_byte());
        repeat (6) send_tick();
    endtask

    task automatic test_collector_full();
        flush_lines();
        send_byte(CH_LF);
        repeat (AT_BUF_SIZE - 1) send_byte(pick_plain_byte());
        send_byte(CH_LF);
        send_text("OK");
    endtask

    task automatic test_store_wrap();
        no_gaps = 1'b1;
        // top up to the wrap point; a full store reads as empty
        repeat (RX_DEPTH - int'(held_bytes())) send_byte(pick_plain_byte());
        send_read(7'd64);
        repeat (4) send_byte(pick_non_lf());
        send_byte(CH_LF);
        send_read(7'd64);
        flush_lines();
        no_gaps = 1'b0;
    endtask

    task automatic random_sequence();
        int kind, len;
        kind = $urandom_range(0, 9);
        no_gaps = ($urandom_range(0, 5) == 0);
        case (kind)
            0, 1, 2, 3:
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 70)
                                                  : $urandom_range(0, 8);
                repeat (len)
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_byte(CH_CR);
                    else
                        send_byte(pick_non_lf());
                end
                if ($urandom_range(0, 1))
                    send_byte(CH_CR);
                send_byte(CH_LF);
            end
            4:
            begin
                repeat ($urandom_range(0, 3)) send_byte(pick_plain_byte());
                if ($urandom_range(0, 1))
                    send_text("OK");
                else
                    send_text("ERR");
                if ($urandom_range(0, 1))
                    send_text("\r\n");
            end
            5, 6:
            begin
                if ($urandom_range(0, 2) == 0)
                    send_read(7'($urandom_range(0, 8)));
                else
                    send_read(7'($urandom_range(0, 127)));
            end
            7:
            begin
                if (timeout_mirror < 40)
                    len = $urandom_range(1, int'(timeout_mirror) + 3);
                else
                    len = $urandom_range(1, 5);
                repeat (len) send_tick();
            end
            8:
            begin
                repeat ($urandom_range(1, 3))
                begin
                    if ($urandom_range(0, 1))
                        send_nop();
                    else
                        send_byte(8'($urandom_range(0, 255)));
                end
            end
            default:
            begin
                if ($urandom_range(0, 1))
                    send_byte(CH_O);
                else
                    send_text("ER");
                send_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic test_random();
        logic [TIMEOUT_W-1:0] settings[5];
        int stop_at;
        settings[0] = 16'd0;
        settings[1] = 16'hFFFF;
        settings[2] = TIMEOUT_W'($urandom_range(1, 20));
        settings[3] = TIMEOUT_W'($urandom_range(0, 65535));
        settings[4] = 16'd2;
        foreach (settings[p])
        begin
            set_idle_timeout(settings[p]);
            stop_at = items_sent + 6;
            while (items_sent < stop_at)
                random_sequence();
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_idle_timeout();
        test_collector_full();
        test_store_wrap();
        test_random();
        wait_idle();
        repeat (16) @(posedge clk);
        $display("Run covered %0d items, %0d line reads returning %0d characters,",
                 items_sent, reads_sent, chars_read);
        $display("%0d timeout register writes and %0d checked results",
                 timeout_writes, results_seen);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Timeout waiting for the block");
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ uart_line_receive_buffer_top.f @@
sv/ulrb_pkg.sv
sv/ulrb_link.sv
sv/ulrb_line.sv
sv/uart_line_receive_buffer_top.sv
dv/tb_top.sv
